// ----- design/edge_chip_run_detector_defines.svh -----
// Assertion macros of the edge chip run detector, used by ecrd_run.
`ifndef EDGE_CHIP_RUN_DETECTOR_DEFINES_SVH
`define EDGE_CHIP_RUN_DETECTOR_DEFINES_SVH

`ifndef ASSERT_OFF

`define ECRD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("edge chip run detector: same-cycle check failed");

`define ECRD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("edge chip run detector: next-cycle check failed");

`else

`define ECRD_ASSERT_SAME(label, clk, rstn, ante, cons)

`define ECRD_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- design/ecrd_pkg.sv -----
// Shared constants and types of the edge chip run detector.
package ecrd_pkg;

    localparam int COORD_W    = 12;
    localparam int PROFILE_W  = 54;
    localparam int AVAIL_W    = 6;
    localparam int DEPTH_W    = 6;
    localparam int COUNT_W    = 12;
    localparam int MAX_DEPTH  = 50;
    localparam int WIN_SPAN   = 4;

    localparam int IN_FIELDS_W  = 2 * COORD_W + PROFILE_W + AVAIL_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * COORD_W + COUNT_W + DEPTH_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_TH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_TH = 1'b1;

    localparam logic [DEPTH_W-1:0] DEPTH_TH_RESET  = 6'd5;
    localparam logic [COUNT_W-1:0] LENGTH_TH_RESET = 12'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

    typedef struct packed {
        logic               off_image;
        logic               last_of_edge;
        logic [COORD_W-1:0] pos_along;
        logic [COORD_W-1:0] pos_across;
    } t_step_info;

    // Packed with start_along in the lowest bits.
    typedef struct packed {
        logic [DEPTH_W-1:0] max_depth;
        logic [COUNT_W-1:0] run_length;
        logic [COORD_W-1:0] start_across;
        logic [COORD_W-1:0] start_along;
    } t_result;

endpackage

// ----- design/ecrd_depth.sv -----
// Chip depth search: first offset with five set profile bits, limited by image end.
module ecrd_depth (
    input  logic [ecrd_pkg::PROFILE_W-1:0] i_profile_bits,
    input  logic [ecrd_pkg::AVAIL_W-1:0]   i_avail_pixels,
    output logic [ecrd_pkg::DEPTH_W-1:0]   o_depth
);

    logic [ecrd_pkg::MAX_DEPTH-1:0] win_hit;
    logic [ecrd_pkg::DEPTH_W-1:0]   win_depth;
    logic [ecrd_pkg::AVAIL_W-1:0]   avail_sat;
    logic [ecrd_pkg::DEPTH_W-1:0]   avail_depth;

    always_comb begin
        for (int d = 0; d < ecrd_pkg::MAX_DEPTH; d++) begin
            win_hit[d] = &i_profile_bits[d +: ecrd_pkg::WIN_SPAN + 1];
        end
    end

    // Priority encode, lowest offset wins; no hit gives the full depth.
    always_comb begin
        win_depth = ecrd_pkg::DEPTH_W'(ecrd_pkg::MAX_DEPTH);
        for (int d = ecrd_pkg::MAX_DEPTH - 1; d >= 0; d--) begin
            if (win_hit[d]) begin
                win_depth = ecrd_pkg::DEPTH_W'(d);
            end
        end
    end

    // The search stops at the first offset whose window would reach past the image.
    always_comb begin
        if (i_avail_pixels > ecrd_pkg::AVAIL_W'(ecrd_pkg::PROFILE_W)) begin
            avail_sat = ecrd_pkg::AVAIL_W'(ecrd_pkg::PROFILE_W);
        end else begin
            avail_sat = i_avail_pixels;
        end
        if (avail_sat > ecrd_pkg::AVAIL_W'(ecrd_pkg::WIN_SPAN)) begin
            avail_depth = ecrd_pkg::DEPTH_W'(avail_sat - ecrd_pkg::AVAIL_W'(ecrd_pkg::WIN_SPAN));
        end else begin
            avail_depth = '0;
        end
    end

    assign o_depth = (avail_depth < win_depth) ? avail_depth : win_depth;

endmodule

// ----- design/ecrd_run.sv -----
// Chip run tracker with the result register.
`include "edge_chip_run_detector_defines.svh"

module ecrd_run (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  ecrd_pkg::t_step_info            i_info,
    input  logic [ecrd_pkg::DEPTH_W-1:0]    i_depth,
    input  logic [ecrd_pkg::DEPTH_W-1:0]    i_depth_th,
    input  logic [ecrd_pkg::COUNT_W-1:0]    i_length_th,
    input  logic                            i_m_tready,
    output logic                            o_can_step,
    output logic                            o_m_tvalid,
    output ecrd_pkg::t_result               o_result
);

    logic                         r_in_run;
    logic [ecrd_pkg::COORD_W-1:0] r_start_along;
    logic [ecrd_pkg::COORD_W-1:0] r_start_across;
    logic [ecrd_pkg::COUNT_W-1:0] r_run_count;
    logic [ecrd_pkg::DEPTH_W-1:0] r_run_depth_max;
    logic                         r_out_valid;
    ecrd_pkg::t_result            r_result;

    logic                         deep;
    logic                         closing;
    logic                         report;
    logic                         c_in_run;
    logic [ecrd_pkg::COORD_W-1:0] c_start_along;
    logic [ecrd_pkg::COORD_W-1:0] c_start_across;
    logic [ecrd_pkg::COUNT_W-1:0] c_run_count;
    logic [ecrd_pkg::DEPTH_W-1:0] c_run_depth_max;
    logic                         n_out_valid;

    assign o_can_step = !r_out_valid || i_m_tready;

    assign deep    = !i_info.off_image && (i_depth > i_depth_th);
    assign closing = (!i_info.off_image && !deep) || i_info.last_of_edge;

    // Run state after this position, before any close.
    always_comb begin
        c_in_run        = r_in_run;
        c_start_along   = r_start_along;
        c_start_across  = r_start_across;
        c_run_count     = r_run_count;
        c_run_depth_max = r_run_depth_max;
        if (deep) begin
            if (!r_in_run) begin
                c_in_run        = 1'b1;
                c_start_along   = i_info.pos_along;
                c_start_across  = i_info.pos_across;
                c_run_count     = ecrd_pkg::COUNT_W'(1);
                c_run_depth_max = i_depth;
            end else begin
                if (i_depth > r_run_depth_max) begin
                    c_run_depth_max = i_depth;
                end
                if (r_run_count != ecrd_pkg::COUNT_MAX) begin
                    c_run_count = r_run_count + ecrd_pkg::COUNT_W'(1);
                end
            end
        end
    end

    assign report = closing && c_in_run && (c_run_count >= i_length_th);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run        <= 1'b0;
            r_start_along   <= '0;
            r_start_across  <= '0;
            r_run_count     <= '0;
            r_run_depth_max <= '0;
        end else if (i_step) begin
            if (closing) begin
                r_in_run        <= 1'b0;
                r_start_along   <= '0;
                r_start_across  <= '0;
                r_run_count     <= '0;
                r_run_depth_max <= '0;
            end else begin
                r_in_run        <= c_in_run;
                r_start_along   <= c_start_along;
                r_start_across  <= c_start_across;
                r_run_count     <= c_run_count;
                r_run_depth_max <= c_run_depth_max;
            end
        end
    end

    always_comb begin
        if (i_step && report) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && report) begin
            r_result.start_along  <= c_start_along;
            r_result.start_across <= c_start_across;
            r_result.run_length   <= c_run_count;
            r_result.max_depth    <= c_run_depth_max;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_result   = r_result;

    `ECRD_ASSERT_SAME(a_idle_count_zero, i_clk, i_rst_n, !r_in_run, r_run_count == '0)
    `ECRD_ASSERT_SAME(a_run_count_nonzero, i_clk, i_rst_n, r_in_run, r_run_count != '0)
    `ECRD_ASSERT_SAME(a_run_depth_nonzero, i_clk, i_rst_n, r_in_run, r_run_depth_max != '0)
    `ECRD_ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, i_step && i_info.last_of_edge, !r_in_run)
    `ECRD_ASSERT_NEXT(a_state_holds, i_clk, i_rst_n, !i_step, r_in_run == $past(r_in_run))

endmodule

// ----- design/edge_chip_run_detector.sv -----
// Top level of the edge chip run detector: ports, settings, input register.
//
// Takes one edge position per clock and reports each closed chip run that is
// long enough as one output word. A word accepted at one edge is held in the
// input register, where its chip depth is found by a 50-window priority encoder
// and the next run state is computed in the same cycle; a report is loaded into
// the result register when the word steps on, and that register drives
// o_m_tvalid. Throughput is one word per cycle for as long as the output side
// takes results; while a result waits untaken in the result register no word
// steps, and the input stalls once the input register is full and cannot step.
// The user must write thresholds through the configuration port only while no
// word is in flight, which the block does not enforce; there is no clearing pass after reset.
module edge_chip_run_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input word. tdata from bit 0: pos_along, pos_across, profile_bits,
    // avail_pixels, zero pad. tuser: off_image. tlast: last_of_edge.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [ecrd_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic                              i_s_tuser,
    input  logic                              i_s_tlast,
    // Result word. tdata from bit 0: start_along, start_across, run_length,
    // max_depth, zero pad.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [ecrd_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // Configuration: index 0 depth_threshold, index 1 length_threshold.
    input  logic                              i_cfg_we,
    input  logic [ecrd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ecrd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int ALONG_LO  = 0;
    localparam int ACROSS_LO = ecrd_pkg::COORD_W;
    localparam int PROF_LO   = 2 * ecrd_pkg::COORD_W;
    localparam int AVAIL_LO  = PROF_LO + ecrd_pkg::PROFILE_W;

    logic [ecrd_pkg::DEPTH_W-1:0]   r_depth_th;
    logic [ecrd_pkg::COUNT_W-1:0]   r_length_th;

    logic                           r_s1_valid;
    ecrd_pkg::t_step_info           r_s1_info;
    logic [ecrd_pkg::PROFILE_W-1:0] r_s1_profile;
    logic [ecrd_pkg::AVAIL_W-1:0]   r_s1_avail;

    logic                           can_step;
    logic                           step;
    logic                           in_take;
    logic [ecrd_pkg::DEPTH_W-1:0]   depth;
    ecrd_pkg::t_result              result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_th  <= ecrd_pkg::DEPTH_TH_RESET;
            r_length_th <= ecrd_pkg::LENGTH_TH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ecrd_pkg::REG_DEPTH_TH:  r_depth_th  <= i_cfg_data[ecrd_pkg::DEPTH_W-1:0];
                ecrd_pkg::REG_LENGTH_TH: r_length_th <= i_cfg_data[ecrd_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign step       = r_s1_valid && can_step;
    assign o_s_tready = !r_s1_valid || can_step;
    assign in_take    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_info.pos_along    <= i_s_tdata[ALONG_LO +: ecrd_pkg::COORD_W];
            r_s1_info.pos_across   <= i_s_tdata[ACROSS_LO +: ecrd_pkg::COORD_W];
            r_s1_info.off_image    <= i_s_tuser;
            r_s1_info.last_of_edge <= i_s_tlast;
            r_s1_profile           <= i_s_tdata[PROF_LO +: ecrd_pkg::PROFILE_W];
            r_s1_avail             <= i_s_tdata[AVAIL_LO +: ecrd_pkg::AVAIL_W];
        end
    end

    ecrd_depth u_depth (
        .i_profile_bits (r_s1_profile),
        .i_avail_pixels (r_s1_avail),
        .o_depth        (depth)
    );

    ecrd_run u_run (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_info      (r_s1_info),
        .i_depth     (depth),
        .i_depth_th  (r_depth_th),
        .i_length_th (r_length_th),
        .i_m_tready  (i_m_tready),
        .o_can_step  (can_step),
        .o_m_tvalid  (o_m_tvalid),
        .o_result    (result)
    );

    assign o_m_tdata = {{ecrd_pkg::OUT_PAD_W{1'b0}}, result};

endmodule
